// ----- rtl/core/wiggle_reorder_sorter_assert.svh -----
// Assertion helpers for the sorter RTL, included by wrs_back.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef WIGGLE_REORDER_SORTER_ASSERT_SVH
`define WIGGLE_REORDER_SORTER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define WRS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define WRS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define WRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/wrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wrs_pkg;

    // Control fields of the queue head, as seen by the back end.
    typedef struct packed {
        logic valid;
        logic last;
    } t_queue_ctl;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PUT,
        S_EMIT_RD,
        S_EMIT_LD
    } t_back_state;

    // Number of entries in the queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ----- rtl/core/wrs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wrs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/wrs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wrs_front
    import wrs_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_last,
    output t_queue_ctl                 o_q_ctl,
    output logic      [VALUE_BITS-1:0] o_q_value,
    input  wire logic                  i_pop
);

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [VALUE_BITS-1:0] r_value [QUEUE_DEPTH];
    logic                  r_last  [QUEUE_DEPTH];
    logic [PW-1:0]         r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]         r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]         r_fill, n_fill;
    logic                  push;
    logic                  pop;

    // Accept a beat whenever a queue slot is free; the back end pops the head.
    assign o_ready       = (r_fill != CW'(QUEUE_DEPTH));
    assign push          = i_valid && o_ready;
    assign pop           = i_pop && (r_fill != '0);
    assign o_q_ctl.valid = (r_fill != '0);
    assign o_q_ctl.last  = r_last[r_rd_ptr];
    assign o_q_value     = r_value[r_rd_ptr];

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_fill = r_fill + CW'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Queue payload storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_value[r_wr_ptr] <= i_value;
            r_last[r_wr_ptr]  <= i_last;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/wrs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wrs_back
    import wrs_pkg::*;
#(
    parameter int unsigned MAX_ELEMS  = 64,
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_queue_ctl            i_q_ctl,
    input  wire logic [VALUE_BITS-1:0] i_q_value,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic      [VALUE_BITS-1:0] o_value_res,
    output logic                       o_last_res
);

`include "wiggle_reorder_sorter_assert.svh"

    localparam int unsigned AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ELEMS + 1);

    t_back_state           r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_pos, n_pos;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                  r_last, n_last;
    logic [AW-1:0]         r_lo, n_lo;
    logic [AW-1:0]         r_hi, n_hi;
    logic [CW-1:0]         r_left, n_left;
    logic                  r_odd, n_odd;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_last;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic                  full;
    logic                  greater;
    logic                  load_ok;
    logic                  first_put;
    logic                  ins_done;
    logic                  emit_start;
    logic [CW-1:0]         emit_n;
    logic [CW-1:0]         emit_nm1;
    logic [CW-1:0]         count_m1;
    logic                  in_emit;
    logic                  final_load;

    // Sorted store.
    wrs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ELEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared conditions.
    assign full      = (r_count == CW'(MAX_ELEMS));
    assign greater   = ($signed(ram_rdata) > $signed(r_val));
    assign load_ok   = !r_out_valid || i_ready;
    assign first_put = (r_state == S_IDLE) && i_q_ctl.valid && !full && (r_count == '0);
    assign ins_done  = first_put || ((r_state == S_CMP) && !greater) || (r_state == S_PUT);
    assign count_m1  = r_count - CW'(1);
    assign emit_n    = ins_done ? (r_count + CW'(1)) : r_count;
    assign emit_nm1  = emit_n - CW'(1);
    assign emit_start = (n_state == S_EMIT_RD) && (r_state != S_EMIT_LD);
    assign in_emit    = (r_state == S_EMIT_RD) || (r_state == S_EMIT_LD);
    assign final_load = (r_state == S_EMIT_LD) && load_ok && (r_left == CW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_ctl.valid) begin
                    if (full || (r_count == '0)) begin
                        n_state = i_q_ctl.last ? S_EMIT_RD : S_IDLE;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (greater) begin
                    n_state = (r_pos == AW'(1)) ? S_PUT : S_CMP;
                end else begin
                    n_state = r_last ? S_EMIT_RD : S_IDLE;
                end
            end
            S_PUT: begin
                n_state = r_last ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (load_ok) begin
                    n_state = (r_left == CW'(1)) ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Store port controls and queue pop.
    always_comb begin
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_val;
        ram_raddr = r_odd ? r_hi : r_lo;
        case (r_state)
            S_IDLE: begin
                o_pop     = i_q_ctl.valid;
                ram_raddr = count_m1[AW-1:0];
                if (first_put) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = i_q_value;
                end
            end
            S_CMP: begin
                // Shift larger entry up a slot, read next lower; else store value.
                ram_we    = 1'b1;
                ram_raddr = r_pos - AW'(2);
                ram_wdata = greater ? ram_rdata : r_val;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
            end
            S_EMIT_RD, S_EMIT_LD: begin
                ram_raddr = r_odd ? r_hi : r_lo;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        n_val   = r_val;
        n_last  = r_last;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_left  = r_left;
        n_odd   = r_odd;
        if ((r_state == S_IDLE) && i_q_ctl.valid) begin
            n_val  = i_q_value;
            n_last = i_q_ctl.last;
            n_pos  = r_count[AW-1:0];
        end
        if ((r_state == S_CMP) && greater) begin
            n_pos = r_pos - AW'(1);
        end
        if (ins_done) begin
            n_count = r_count + CW'(1);
        end
        // Wiggle order starts at the lower median and at the top entry.
        if (emit_start) begin
            n_hi   = emit_nm1[AW-1:0];
            n_lo   = AW'(emit_nm1 >> 1);
            n_left = emit_n;
            n_odd  = 1'b0;
        end
        if ((r_state == S_EMIT_LD) && load_ok) begin
            if (r_odd) begin
                n_hi = (r_hi != '0) ? r_hi - AW'(1) : r_hi;
            end else begin
                n_lo = (r_lo != '0) ? r_lo - AW'(1) : r_lo;
            end
            n_odd  = !r_odd;
            n_left = r_left - CW'(1);
            if (r_left == CW'(1)) begin
                n_count = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if ((r_state == S_EMIT_LD) && load_ok) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_last <= n_last;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_left <= n_left;
        r_odd  <= n_odd;
        if ((r_state == S_EMIT_LD) && load_ok) begin
            r_out_value <= ram_rdata;
            r_out_last  <= (r_left == CW'(1));
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_last_res  = r_out_last;

    `WRS_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(MAX_ELEMS), "element count over capacity")
    `WRS_ASSERT_IMPL(a_no_write_in_emit, in_emit, !ram_we, "store written during emission")
    `WRS_ASSERT_IMPL(a_pos_nonzero, r_state == S_CMP, r_pos != '0, "insertion compare at slot zero")
    `WRS_ASSERT_NEXT(a_count_cleared, final_load, r_count == '0, "count not cleared")

endmodule

`default_nettype wire

// ----- rtl/core/wiggle_reorder_sorter.sv -----
// Once the back end takes a value beat, insertion walks down from the top entry, shifting each
// larger stored entry up one slot (an empty store takes it directly, a full store drops it).
// The beat flagged last then streams the set out in wiggle order via the registered read of the
// single store read port; each result beat is loaded before the next read, waiting while stalled.
// After insertion the first beat passes the read and load states; the input queue holds 2 beats.
// Reset clears the queue, the element count and the output valid; store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module wiggle_reorder_sorter
    import wrs_pkg::*;
#(
    parameter int unsigned MAX_ELEMS  = 64,
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_last,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic      [VALUE_BITS-1:0] o_value_res,
    output logic                       o_last_res
);

    t_queue_ctl            q_ctl;
    logic [VALUE_BITS-1:0] q_value;
    logic                  q_pop;

    // Input queue.
    wrs_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_value   (i_value),
        .i_last    (i_last),
        .o_q_ctl   (q_ctl),
        .o_q_value (q_value),
        .i_pop     (q_pop)
    );

    // Insertion sort and wiggle emission.
    wrs_back #(
        .MAX_ELEMS  (MAX_ELEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_ctl     (q_ctl),
        .i_q_value   (q_value),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res)
    );

endmodule

`default_nettype wire
